[design/imubc_pkg.sv]
// ============================================================================
// imubc_pkg: shared definitions for the IMU bias calibration core
// Axis counts and the status group that each magnitude unit reports.
// ============================================================================
package imubc_pkg;

    localparam int AXES   = 6;
    localparam int AXIS_W = 3;
    localparam int TRIPLE = 3;

    typedef struct packed {
        logic busy;
        logic done;
    } mag_stat_t;

endpackage

[design/imu_bias_calibrate_and_magnitude_core.sv]
// ============================================================================
// imu_bias_calibrate_and_magnitude_core: IMU bias calibration and magnitudes
// Averages the first CAL_SAMPLES readings into per-axis biases, then removes
// the biases from each later reading and returns the floored magnitudes of
// the acceleration and rotation vectors.
// ============================================================================
//
// Channel  Direction  Transfer content
// s_       in         accel_x, accel_y, accel_z, rate_pitch, rate_roll, rate_yaw
// m_       out        accel_magnitude, rotation_magnitude
//
// Calibration transfers are always accepted and give no result.
// After the last one, a restoring divider works through the six axes in
// turn, loading each sum and then shifting out its quotient; s_tready is low.
// Each later reading is squared and rooted bit-serially in the magnitude units;
// s_tready stays low until both units are idle again.
// A waiting result sits in the output register; only a further result stalls.
// Reset is synchronous and restarts calibration.
module imu_bias_calibrate_and_magnitude_core #(
    parameter int CAL_SAMPLES = 128,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // accel_x, accel_y, accel_z, rate_pitch, rate_roll, rate_yaw, zero padding
    input  logic [((6 * SAMPLE_BITS + 7) / 8) * 8 - 1:0]  s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // accel_magnitude, rotation_magnitude, zero padding
    output logic [((2 * SAMPLE_BITS + 9) / 8) * 8 - 1:0]  m_tdata
);

    localparam int SB     = SAMPLE_BITS;
    localparam int MAG_W  = SB + 1;
    localparam int OUT_W  = ((2 * SAMPLE_BITS + 9) / 8) * 8;
    localparam int SUM_W  = SB + $clog2(CAL_SAMPLES);
    localparam int REM_W  = $clog2(CAL_SAMPLES + 1);
    localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
    localparam int DCNT_W = $clog2(SUM_W);
    localparam int AXES   = imubc_pkg::AXES;
    localparam int AX_W   = imubc_pkg::AXIS_W;
    localparam int TRIPLE = imubc_pkg::TRIPLE;

    typedef enum logic [1:0] {S_CAL, S_DIV_LOAD, S_DIV_STEP, S_RUN} state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        cal_cnt_reg;
    logic signed [SUM_W-1:0] sum_reg  [AXES];
    logic signed [SB-1:0]    bias_reg [AXES];
    logic [AX_W-1:0]         axis_reg;
    logic [SUM_W-1:0]        dvd_reg;
    logic [REM_W-1:0]        rem_reg;
    logic                    neg_reg;
    logic [DCNT_W-1:0]       dcnt_reg;
    logic                    m_tvalid_reg;
    logic [2*MAG_W-1:0]      m_data_reg;

    logic signed [SB-1:0]    samp [AXES];
    logic signed [SB:0]      corr_acc [TRIPLE];
    logic signed [SB:0]      corr_rot [TRIPLE];
    logic signed [SUM_W-1:0] sel_sum;
    logic [SUM_W-1:0]        sel_neg;
    logic [REM_W:0]          rem_sh;
    logic [REM_W:0]          rem_sub;
    logic                    quot_bit;
    logic [SUM_W-1:0]        quot;
    logic [SB-1:0]           bias_new;

    logic                    s_accept;
    logic                    calc_start;
    logic                    res_take;
    imubc_pkg::mag_stat_t    acc_stat;
    imubc_pkg::mag_stat_t    rot_stat;
    logic [MAG_W-1:0]        acc_root;
    logic [MAG_W-1:0]        rot_root;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            samp[i] = signed'(s_tdata[i*SB +: SB]);
        end
        for (int i = 0; i < TRIPLE; i++) begin
            corr_acc[i] = (SB + 1)'(samp[i]) - (SB + 1)'(bias_reg[i]);
            corr_rot[i] = (SB + 1)'(samp[i + TRIPLE]) - (SB + 1)'(bias_reg[i + TRIPLE]);
        end
    end

    assign sel_sum  = sum_reg[axis_reg];
    assign sel_neg  = -sel_sum;
    assign rem_sh   = {rem_reg, dvd_reg[SUM_W-1]};
    assign quot_bit = (rem_sh >= (REM_W + 1)'(CAL_SAMPLES));
    assign rem_sub  = rem_sh - (REM_W + 1)'(CAL_SAMPLES);
    assign quot     = {dvd_reg[SUM_W-2:0], quot_bit};
    assign bias_new = neg_reg ? -quot[SB-1:0] : quot[SB-1:0];

    always_comb begin
        unique case (state_reg)
            S_CAL:   s_tready = 1'b1;
            S_RUN:   s_tready = !acc_stat.busy && !rot_stat.busy;
            default: s_tready = 1'b0;
        endcase
    end

    assign s_accept   = s_tvalid && s_tready;
    assign calc_start = s_accept && (state_reg == S_RUN);
    assign res_take   = acc_stat.done && rot_stat.done && (!m_tvalid_reg || m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'(m_data_reg);

    imubc_mag #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_acc_mag (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (calc_start),
        .ack      (res_take),
        .axis_val (corr_acc),
        .stat     (acc_stat),
        .root     (acc_root)
    );

    imubc_mag #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rot_mag (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (calc_start),
        .ack      (res_take),
        .axis_val (corr_rot),
        .stat     (rot_stat),
        .root     (rot_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CAL;
            cal_cnt_reg  <= '0;
            axis_reg     <= '0;
            dcnt_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                sum_reg[i] <= '0;
            end
        end else begin
            unique case (state_reg)
                S_CAL: begin
                    if (s_accept) begin
                        for (int i = 0; i < AXES; i++) begin
                            sum_reg[i] <= sum_reg[i] + SUM_W'(samp[i]);
                        end
                        cal_cnt_reg <= cal_cnt_reg + 1'b1;
                        if (cal_cnt_reg == CNT_W'(CAL_SAMPLES - 1)) begin
                            axis_reg  <= '0;
                            state_reg <= S_DIV_LOAD;
                        end
                    end
                end
                S_DIV_LOAD: begin
                    dvd_reg   <= sel_sum[SUM_W-1] ? sel_neg : sel_sum;
                    neg_reg   <= sel_sum[SUM_W-1];
                    rem_reg   <= '0;
                    dcnt_reg  <= DCNT_W'(SUM_W - 1);
                    state_reg <= S_DIV_STEP;
                end
                S_DIV_STEP: begin
                    rem_reg <= quot_bit ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
                    dvd_reg <= quot;
                    if (dcnt_reg == '0) begin
                        bias_reg[axis_reg] <= bias_new;
                        if (axis_reg == AX_W'(AXES - 1)) begin
                            state_reg <= S_RUN;
                        end else begin
                            axis_reg  <= axis_reg + 1'b1;
                            state_reg <= S_DIV_LOAD;
                        end
                    end else begin
                        dcnt_reg <= dcnt_reg - 1'b1;
                    end
                end
                S_RUN: begin
                end
                default: begin
                    state_reg <= S_CAL;
                end
            endcase

            if (res_take) begin
                m_tvalid_reg <= 1'b1;
                m_data_reg   <= {rot_root, acc_root};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

[design/imubc_mag.sv]
// ============================================================================
// imubc_mag: bit-serial vector magnitude of one axis triple
// Squares and sums three signed values with a shift-and-add accumulator that
// takes one multiplier bit per cycle, then extracts the floored square root
// one result bit per cycle. The result is held until it is acknowledged.
// ============================================================================
module imubc_mag #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic                         ack,
    input  logic signed [SAMPLE_BITS:0]  axis_val [imubc_pkg::TRIPLE],
    output imubc_pkg::mag_stat_t         stat,
    output logic        [SAMPLE_BITS:0]  root
);

    localparam int SB    = SAMPLE_BITS;
    localparam int ACC_W = 2 * SB + 2;
    localparam int RM_W  = SB + 2;
    localparam int CNT_W = $clog2(SB + 2);

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_ROOT, M_DONE} state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SB-1:0]     mcand_reg [imubc_pkg::TRIPLE];
    logic [SB-1:0]     mpl_reg   [imubc_pkg::TRIPLE];
    logic [ACC_W-1:0]  acc_reg;
    logic [RM_W-1:0]   rem_reg;
    logic [SB:0]       root_reg;

    logic [SB-1:0]     mag_in  [imubc_pkg::TRIPLE];
    logic [ACC_W-1:0]  acc_next;
    logic [RM_W+1:0]   rem_sh;
    logic [RM_W+1:0]   trial;
    logic [RM_W+1:0]   rem_sub;
    logic              fits;

    always_comb begin
        acc_next = {acc_reg[ACC_W-2:0], 1'b0};
        for (int i = 0; i < imubc_pkg::TRIPLE; i++) begin
            logic [SB:0] neg_val;
            neg_val   = -axis_val[i];
            mag_in[i] = axis_val[i][SB] ? neg_val[SB-1:0] : axis_val[i][SB-1:0];
            if (mpl_reg[i][SB-1]) begin
                acc_next = acc_next + ACC_W'(mcand_reg[i]);
            end
        end
    end

    assign rem_sh  = {rem_reg, acc_reg[ACC_W-1:ACC_W-2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign fits    = (rem_sh >= trial);
    assign rem_sub = rem_sh - trial;

    assign stat.busy = (state_reg != M_IDLE);
    assign stat.done = (state_reg == M_DONE);
    assign root      = root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                M_IDLE: begin
                    if (start) begin
                        for (int i = 0; i < imubc_pkg::TRIPLE; i++) begin
                            mcand_reg[i] <= mag_in[i];
                            mpl_reg[i]   <= mag_in[i];
                        end
                        acc_reg   <= '0;
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= CNT_W'(SB - 1);
                        state_reg <= M_MUL;
                    end
                end
                M_MUL: begin
                    acc_reg <= acc_next;
                    for (int i = 0; i < imubc_pkg::TRIPLE; i++) begin
                        mpl_reg[i] <= {mpl_reg[i][SB-2:0], 1'b0};
                    end
                    if (cnt_reg == '0) begin
                        cnt_reg   <= CNT_W'(SB);
                        state_reg <= M_ROOT;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                M_ROOT: begin
                    acc_reg  <= {acc_reg[ACC_W-3:0], 2'b00};
                    rem_reg  <= fits ? rem_sub[RM_W-1:0] : rem_sh[RM_W-1:0];
                    root_reg <= {root_reg[SB-1:0], fits};
                    if (cnt_reg == '0) begin
                        state_reg <= M_DONE;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                M_DONE: begin
                    if (ack) begin
                        state_reg <= M_IDLE;
                    end
                end
                default: begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

endmodule

[design/imubc_chk.sv]
// ============================================================================
// imubc_chk: port-level checks for the IMU bias calibration core
// Watches the stream ports over time and is bound to the top level.
// ============================================================================
module imubc_chk #(
    parameter int CAL_SAMPLES = 128,
    parameter int SAMPLE_BITS = 16
) (
    input logic                                          aclk,
    input logic                                          aresetn,
    input logic                                          s_tvalid,
    input logic                                          s_tready,
    input logic                                          m_tvalid,
    input logic                                          m_tready,
    input logic [((2 * SAMPLE_BITS + 9) / 8) * 8 - 1:0]  m_tdata
);

    localparam int SEEN_W = $clog2(CAL_SAMPLES + 2);

    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;

    assign seen_next = (s_tvalid && s_tready && seen_reg != SEEN_W'(CAL_SAMPLES + 1))
                       ? seen_reg + 1'b1 : seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else begin
            seen_reg <= seen_next;
        end
    end

    // No result may appear until a reading beyond the calibration run has arrived.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> seen_reg == SEEN_W'(CAL_SAMPLES + 1))
        else $error("result transfer before calibration completed");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >> (2 * SAMPLE_BITS + 2)) == '0)
        else $error("result padding bits not zero");

endmodule

bind imu_bias_calibrate_and_magnitude_core imubc_chk #(
    .CAL_SAMPLES (CAL_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_imubc_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
